>>> hw/rtl/rpm_pkg.sv
// ----------------------------------------------------------------------------
// rpm_pkg
// Shared types, field widths, item codes and the sequencer program for the
// revisited pose matcher.
// ----------------------------------------------------------------------------
package rpm_pkg;

  localparam int POS_W    = 21;
  localparam int HEAD_W   = 16;
  localparam int KIND_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int DIST_W   = 16;
  localparam int ANG_W    = 15;
  localparam int CFG_IX_W = 1;
  localparam int CFG_D_W  = 16;
  localparam int POSE_W   = 3 * POS_W + HEAD_W;

  localparam logic [KIND_W-1:0] KIND_RECORD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  localparam logic [CFG_IX_W-1:0] CFG_DIST = 1'd0;
  localparam logic [CFG_IX_W-1:0] CFG_ANG  = 1'd1;

  localparam logic [DIST_W-1:0] DIST_RESET = 16'd256;
  localparam logic [ANG_W-1:0]  ANG_RESET  = 15'd2287;

  localparam logic [HEAD_W:0]     Q13_PI     = 17'd25736;
  localparam logic signed [17:0]  Q13_TWO_PI = 18'sd51472;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_REC,
    ST_CLR,
    ST_QINIT,
    ST_QDIFF,
    ST_QMUL,
    ST_QCMP,
    ST_OUT
  } step_t;

  typedef enum logic [3:0] {
    OP_LATCH,
    OP_NONE,
    OP_RECORD,
    OP_CLEAR,
    OP_QINIT,
    OP_DIFF,
    OP_MUL,
    OP_CMP,
    OP_PRESENT
  } op_t;

  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_IN,
    JC_KIND,
    JC_EMPTY,
    JC_LOOP,
    JC_OUT_FREE
  } jc_t;

  typedef struct packed {
    op_t   op;
    jc_t   jc;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    case (s)
      ST_IDLE:   w = '{op: OP_LATCH,   jc: JC_IN,       target: ST_IDLE};
      ST_DECODE: w = '{op: OP_NONE,    jc: JC_KIND,     target: ST_OUT};
      ST_REC:    w = '{op: OP_RECORD,  jc: JC_ALWAYS,   target: ST_OUT};
      ST_CLR:    w = '{op: OP_CLEAR,   jc: JC_ALWAYS,   target: ST_OUT};
      ST_QINIT:  w = '{op: OP_QINIT,   jc: JC_EMPTY,    target: ST_OUT};
      ST_QDIFF:  w = '{op: OP_DIFF,    jc: JC_NEXT,     target: ST_QDIFF};
      ST_QMUL:   w = '{op: OP_MUL,     jc: JC_NEXT,     target: ST_QMUL};
      ST_QCMP:   w = '{op: OP_CMP,     jc: JC_LOOP,     target: ST_QDIFF};
      ST_OUT:    w = '{op: OP_PRESENT, jc: JC_OUT_FREE, target: ST_IDLE};
      default:   w = '{op: OP_NONE,    jc: JC_ALWAYS,   target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/rpm_pose_mem.sv
// ----------------------------------------------------------------------------
// rpm_pose_mem
// Pose table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rpm_pose_mem
  import rpm_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [POSE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [POSE_W-1:0] rd_data
);

  logic [POSE_W-1:0] mem [DEPTH];
  logic [POSE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/revisited_pose_matcher.sv
// ----------------------------------------------------------------------------
// revisited_pose_matcher
// Table of visited poses with an inclusive position and yaw revisit test.
//
// Input channel (in_*): one transaction per item; kind 0 records a pose,
// 1 queries it against the table, 2 clears the table, 3 does nothing.
// Every item yields exactly one transaction on the result channel (out_*).
// Config channel (cfg_*): index 0 writes the distance threshold, index 1
// the angle threshold; always ready, meant to be written while idle.
// A query scans the table entries and stops at the first match. Each
// scanned entry takes 3 steps of the microcoded sequencer: difference,
// square, sum and compare. The next item is taken the cycle after its
// predecessor's result is registered.
// Reset empties the table and loads threshold defaults (1.0 m, about 16
// degrees). A stalled receiver holds the result; the block takes one more
// item and then waits with its result until out_ready.
// ----------------------------------------------------------------------------
module revisited_pose_matcher
  import rpm_pkg::*;
#(
  parameter int MAX_POSES = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [POS_W-1:0]  in_pos_x,
  input  logic signed [POS_W-1:0]  in_pos_y,
  input  logic signed [POS_W-1:0]  in_pos_z,
  input  logic signed [HEAD_W-1:0] in_heading,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_already_visited,
  output logic [COUNT_W-1:0]       out_stored_count,
  output logic                     out_dropped,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IX_W-1:0]      cfg_index,
  input  logic [CFG_D_W-1:0]       cfg_data
);

  localparam int CW = $clog2(MAX_POSES + 1);
  localparam int AW = (MAX_POSES > 1) ? $clog2(MAX_POSES) : 1;

  step_t  step_r, step_nxt;
  ucode_t uw;

  logic [DIST_W-1:0] dist_th_r;
  logic [ANG_W-1:0]  ang_th_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     idx_r;

  logic [KIND_W-1:0]        kind_r;
  logic signed [POS_W-1:0]  x_r, y_r, z_r;
  logic signed [HEAD_W-1:0] hd_r;

  logic [POS_W:0]        mag_x_r, mag_y_r, mag_z_r;
  logic [HEAD_W:0]       yaw_abs_r;
  logic [2*POS_W+1:0]    sq_x_r, sq_y_r, sq_z_r;
  logic                  yaw_ok_r;
  logic [2*DIST_W-1:0]   th_sq_r;
  logic                  visited_r, dropped_r;

  logic                  out_valid_r;
  logic                  out_visited_r, out_dropped_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic in_xfer, out_free, full, last, hit;
  logic [CW-1:0] idx_inc;

  logic              wr_en, rd_en;
  logic [AW-1:0]     rd_addr;
  logic [POSE_W-1:0] wr_data, rd_data;

  logic signed [POS_W-1:0]  px, py, pz;
  logic signed [HEAD_W-1:0] ph;
  logic signed [POS_W:0]    dx, dy, dz;
  logic signed [HEAD_W:0]   dh;
  logic signed [17:0]       yaw_wrap;
  logic [2*POS_W+3:0]       dist_sum;
  logic                     yaw_ok;

  assign uw       = ucode_rom(step_r);
  assign in_ready = (step_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign full    = (count_r >= CW'(MAX_POSES));
  assign idx_inc = CW'(idx_r) + CW'(1);
  assign last    = (idx_inc == count_r);

  // datapath combinational terms
  assign {px, py, pz, ph} = rd_data;
  assign dx = {x_r[POS_W-1], x_r} - {px[POS_W-1], px};
  assign dy = {y_r[POS_W-1], y_r} - {py[POS_W-1], py};
  assign dz = {z_r[POS_W-1], z_r} - {pz[POS_W-1], pz};
  assign dh = {hd_r[HEAD_W-1], hd_r} - {ph[HEAD_W-1], ph};

  assign yaw_wrap = Q13_TWO_PI - $signed({1'b0, yaw_abs_r});
  assign yaw_ok   = (yaw_abs_r > Q13_PI) ?
                    (yaw_wrap <= $signed({3'b000, ang_th_r})) :
                    (yaw_abs_r <= {2'b00, ang_th_r});

  assign dist_sum = {2'b00, sq_x_r} + {2'b00, sq_y_r} + {2'b00, sq_z_r};
  assign hit      = (dist_sum <= (2*POS_W+4)'(th_sq_r)) && yaw_ok_r;

  assign wr_en   = (uw.op == OP_RECORD) && !full;
  assign wr_data = {x_r, y_r, z_r, hd_r};
  assign rd_en   = (uw.op == OP_QINIT) || ((uw.op == OP_CMP) && !last && !hit);
  assign rd_addr = (uw.op == OP_QINIT) ? '0 : idx_inc[AW-1:0];

  rpm_pose_mem #(
    .DEPTH (MAX_POSES),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer: next step from the control word
  always_comb begin
    step_nxt = step_t'(step_r + 4'd1);
    case (uw.jc)
      JC_NEXT: begin
      end
      JC_ALWAYS: begin
        step_nxt = uw.target;
      end
      JC_IN: begin
        if (!in_xfer) begin
          step_nxt = step_r;
        end
      end
      JC_KIND: begin
        case (kind_r)
          KIND_RECORD: step_nxt = ST_REC;
          KIND_QUERY:  step_nxt = ST_QINIT;
          KIND_CLEAR:  step_nxt = ST_CLR;
          default:     step_nxt = uw.target;
        endcase
      end
      JC_EMPTY: begin
        if (count_r == '0) begin
          step_nxt = uw.target;
        end
      end
      JC_LOOP: begin
        if (!hit && !last) begin
          step_nxt = uw.target;
        end
      end
      JC_OUT_FREE: begin
        step_nxt = out_free ? uw.target : step_r;
      end
      default: begin
        step_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      count_r     <= '0;
      dist_th_r   <= DIST_RESET;
      ang_th_r    <= ANG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DIST: dist_th_r <= cfg_data[DIST_W-1:0];
          CFG_ANG:  ang_th_r  <= cfg_data[ANG_W-1:0];
          default: begin
          end
        endcase
      end

      if ((uw.op == OP_PRESENT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (uw.op)
        OP_LATCH: begin
          if (in_xfer) begin
            kind_r    <= in_kind;
            x_r       <= in_pos_x;
            y_r       <= in_pos_y;
            z_r       <= in_pos_z;
            hd_r      <= in_heading;
            visited_r <= 1'b0;
            dropped_r <= 1'b0;
          end
        end
        OP_RECORD: begin
          if (full) begin
            dropped_r <= 1'b1;
          end else begin
            count_r <= count_r + CW'(1);
          end
        end
        OP_CLEAR: begin
          count_r <= '0;
        end
        OP_QINIT: begin
          idx_r   <= '0;
          th_sq_r <= dist_th_r * dist_th_r;
        end
        OP_DIFF: begin
          mag_x_r   <= dx[POS_W] ? (POS_W+1)'(-dx) : (POS_W+1)'(dx);
          mag_y_r   <= dy[POS_W] ? (POS_W+1)'(-dy) : (POS_W+1)'(dy);
          mag_z_r   <= dz[POS_W] ? (POS_W+1)'(-dz) : (POS_W+1)'(dz);
          yaw_abs_r <= dh[HEAD_W] ? (HEAD_W+1)'(-dh) : (HEAD_W+1)'(dh);
        end
        OP_MUL: begin
          sq_x_r   <= mag_x_r * mag_x_r;
          sq_y_r   <= mag_y_r * mag_y_r;
          sq_z_r   <= mag_z_r * mag_z_r;
          yaw_ok_r <= yaw_ok;
        end
        OP_CMP: begin
          if (hit) begin
            visited_r <= 1'b1;
          end else if (!last) begin
            idx_r <= idx_inc[AW-1:0];
          end
        end
        OP_PRESENT: begin
          if (out_free) begin
            out_visited_r <= visited_r;
            out_dropped_r <= dropped_r;
            out_count_r   <= COUNT_W'(count_r);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_already_visited = out_visited_r;
  assign out_stored_count    = out_count_r;
  assign out_dropped         = out_dropped_r;

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for revisited_pose_matcher. A built-in predictor keeps
// its own pose table and thresholds, scores every accepted item, and queues
// the expected verdicts for comparison against the result channel. Directed
// checks come first: empty table, inclusive limits, yaw wrap, out-of-range
// yaw, full table, unused kind. After them come threshold extremes, an
// output stall and randomized record/query/clear traffic with random idling.
// ----------------------------------------------------------------------------
module testbench
  import rpm_pkg::*;
();

  localparam int TABLE_DEPTH = 64;
  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_TAIL  = 40;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [DIST_W-1:0] RADIUS_AT_RESET = 16'd256;
  localparam logic [ANG_W-1:0]  TOL_AT_RESET    = 15'd2287;

  localparam longint YAW_PI     = 25736;
  localparam longint YAW_TWO_PI = 51472;
  localparam longint COORD_MAX  = 1048575;
  localparam longint COORD_MIN  = -1048576;

  typedef logic signed [POS_W-1:0]  coord_t;
  typedef logic signed [HEAD_W-1:0] yaw_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    yaw_t   h;
  } pose_t;

  typedef struct packed {
    logic               hit;
    logic [COUNT_W-1:0] count;
    logic               drop;
  } verdict_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind;
  coord_t              in_pos_x;
  coord_t              in_pos_y;
  coord_t              in_pos_z;
  yaw_t                in_heading;
  logic                out_valid;
  logic                out_ready;
  logic                out_already_visited;
  logic [COUNT_W-1:0]  out_stored_count;
  logic                out_dropped;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IX_W-1:0] cfg_index;
  logic [CFG_D_W-1:0]  cfg_data;

  // predictor state
  pose_t             visited_table [TABLE_DEPTH];
  int                pose_count = 0;
  logic [DIST_W-1:0] radius_q8 = RADIUS_AT_RESET;
  logic [ANG_W-1:0]  yaw_tol = TOL_AT_RESET;

  verdict_t expected_verdicts [$];
  int       mismatches = 0;
  logic     no_idle = 1'b0;
  logic     hold_results = 1'b0;
  longint   walk_x = 0;
  longint   walk_y = 0;
  longint   walk_z = 0;

  revisited_pose_matcher #(
    .MAX_POSES(TABLE_DEPTH)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_pos_x            (in_pos_x),
    .in_pos_y            (in_pos_y),
    .in_pos_z            (in_pos_z),
    .in_heading          (in_heading),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_already_visited (out_already_visited),
    .out_stored_count    (out_stored_count),
    .out_dropped         (out_dropped),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic coord_t fit_coord(longint v);
    if (v > COORD_MAX) v = COORD_MAX;
    else if (v < COORD_MIN) v = COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic yaw_t wrap_yaw(longint v);
    if (v > YAW_PI) v = v - YAW_TWO_PI;
    else if (v < -YAW_PI) v = v + YAW_TWO_PI;
    return yaw_t'(v);
  endfunction

  function automatic longint jitter(longint span);
    return longint'($urandom_range(0, 32'(2 * span))) - span;
  endfunction

  function automatic pose_t make_pose(longint x, longint y, longint z, longint h);
    pose_t p;
    p.x = coord_t'(x);
    p.y = coord_t'(y);
    p.z = coord_t'(z);
    p.h = yaw_t'(h);
    return p;
  endfunction

  function automatic int idle_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // inclusive position and yaw test against one stored pose
  function automatic logic near_pose(pose_t stored, pose_t probe);
    longint dx, dy, dz, dist2, lim, dyaw;
    dx = longint'(probe.x) - longint'(stored.x);
    dy = longint'(probe.y) - longint'(stored.y);
    dz = longint'(probe.z) - longint'(stored.z);
    dist2 = dx * dx + dy * dy + dz * dz;
    lim = longint'(radius_q8) * longint'(radius_q8);
    if (dist2 > lim) return 1'b0;
    dyaw = longint'(probe.h) - longint'(stored.h);
    if (dyaw < 0) dyaw = -dyaw;
    if (dyaw > YAW_PI) dyaw = YAW_TWO_PI - dyaw;
    return dyaw <= longint'(yaw_tol);
  endfunction

  function automatic verdict_t judge_pose(logic [KIND_W-1:0] kind, pose_t p);
    verdict_t v;
    int i;
    v = '0;
    case (kind)
      KIND_RECORD: begin
        if (pose_count < TABLE_DEPTH) begin
          visited_table[pose_count] = p;
          pose_count++;
        end else begin
          v.drop = 1'b1;
        end
      end
      KIND_QUERY: begin
        for (i = 0; i < pose_count && !v.hit; i++) begin
          if (near_pose(visited_table[i], p)) v.hit = 1'b1;
        end
      end
      KIND_CLEAR: pose_count = 0;
      default: ;
    endcase
    v.count = pose_count[COUNT_W-1:0];
    return v;
  endfunction

  task automatic send_item(input logic [KIND_W-1:0] kind, input pose_t p);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_pos_x   <= p.x;
    in_pos_y   <= p.y;
    in_pos_z   <= p.z;
    in_heading <= p.h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_verdicts = {expected_verdicts, judge_pose(kind, p)};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [CFG_D_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DIST: radius_q8 = value;
      CFG_ANG:  yaw_tol = value[ANG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [DIST_W-1:0] radius, input logic [ANG_W-1:0] tol);
    wait_drained();
    write_reg(CFG_DIST, radius);
    write_reg(CFG_ANG, CFG_D_W'(tol));
    cfg_valid <= 1'b0;
  endtask

  // random walk of records with queries mostly near stored poses
  task automatic run_survey(input int count, input int clear_pct);
    int i, roll;
    logic [KIND_W-1:0] kind;
    pose_t p, base;
    longint reach, turn, stride;
    for (i = 0; i < count; i++) begin
      reach  = longint'(radius_q8) * 5 / 8 + 2;
      turn   = longint'(yaw_tol) * 5 / 4 + 2;
      stride = 2 * longint'(radius_q8) + 64;
      roll   = $urandom_range(0, 99);
      if (roll < 6) begin
        kind = KIND_W'($urandom_range(0, 3));
        p.x = coord_t'($urandom());
        p.y = coord_t'($urandom());
        p.z = coord_t'($urandom());
        p.h = yaw_t'($urandom());
        send_item(kind, p);
      end else if (roll < 6 + clear_pct) begin
        send_item(KIND_CLEAR, make_pose(jitter(1000), jitter(1000), jitter(1000), 0));
      end else if (roll < 8 + clear_pct) begin
        send_item(KIND_UNUSED, make_pose(walk_x, walk_y, walk_z, jitter(YAW_PI)));
      end else if (roll < 50) begin
        walk_x = fit_coord(walk_x + jitter(stride));
        walk_y = fit_coord(walk_y + jitter(stride));
        walk_z = fit_coord(walk_z + jitter(stride));
        send_item(KIND_RECORD, make_pose(walk_x, walk_y, walk_z, jitter(YAW_PI)));
      end else begin
        if (pose_count > 0 && $urandom_range(0, 9) < 7)
          base = visited_table[$urandom_range(0, pose_count - 1)];
        else
          base = make_pose(walk_x, walk_y, walk_z, jitter(YAW_PI));
        p.x = fit_coord(longint'(base.x) + jitter(reach));
        p.y = fit_coord(longint'(base.y) + jitter(reach));
        p.z = fit_coord(longint'(base.z) + jitter(reach));
        p.h = wrap_yaw(longint'(base.h) + jitter(turn));
        send_item(KIND_QUERY, p);
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_item(KIND_QUERY, make_pose(0, 0, 0, 0));
    send_item(KIND_UNUSED, make_pose(1, 2, 3, 4));
    send_item(KIND_RECORD, make_pose(0, 0, 0, 0));
    send_item(KIND_QUERY, make_pose(0, 0, 0, 0));
    send_item(KIND_QUERY, make_pose(256, 0, 0, 0));
    send_item(KIND_QUERY, make_pose(257, 0, 0, 0));
    send_item(KIND_QUERY, make_pose(0, 0, 0, 2287));
    send_item(KIND_QUERY, make_pose(0, 0, 0, -2288));
    send_item(KIND_RECORD, make_pose(COORD_MAX, COORD_MAX, COORD_MAX, YAW_PI));
    send_item(KIND_RECORD, make_pose(COORD_MIN, COORD_MIN, COORD_MIN, -YAW_PI));
    // +pi against -pi wraps to zero
    send_item(KIND_QUERY, make_pose(COORD_MIN, COORD_MIN, COORD_MIN, YAW_PI));
    send_item(KIND_QUERY, make_pose(COORD_MAX, COORD_MIN, COORD_MAX, 0));
    // yaw beyond pi: wrapped difference goes negative
    send_item(KIND_RECORD, make_pose(5000, -5000, 0, 32767));
    send_item(KIND_QUERY, make_pose(5000, -5000, 0, -32768));
    send_item(KIND_QUERY, make_pose(5000, -5000, 0, 0));
    send_item(KIND_UNUSED, make_pose(0, 0, 0, 0));
    send_item(KIND_CLEAR, make_pose(0, 0, 0, 0));
    send_item(KIND_QUERY, make_pose(0, 0, 0, 0));
    send_item(KIND_QUERY, make_pose(COORD_MAX, COORD_MAX, COORD_MAX, YAW_PI));
  endtask

  task automatic test_table_capacity();
    int i;
    send_item(KIND_CLEAR, make_pose(0, 0, 0, 0));
    for (i = 0; i < TABLE_DEPTH; i++)
      send_item(KIND_RECORD, make_pose(longint'(i) * 512, -longint'(i) * 512,
                                       longint'(i) * 64, longint'(i) * 300 - 9600));
    send_item(KIND_QUERY, make_pose(0, 0, 0, -9600));
    send_item(KIND_QUERY, visited_table[TABLE_DEPTH - 1]);
    send_item(KIND_QUERY, make_pose(256, -256, 32, -9450));
    send_item(KIND_UNUSED, make_pose(0, 0, 0, 0));
    for (i = 0; i < 3; i++)
      send_item(KIND_RECORD, make_pose(jitter(4096), jitter(4096), jitter(4096), jitter(YAW_PI)));
    send_item(KIND_CLEAR, make_pose(0, 0, 0, 0));
  endtask

  task automatic test_threshold_extremes();
    int i;
    set_thresholds(16'd0, 15'd0);
    run_survey(50, 1);
    set_thresholds(16'hFFFF, 15'd25736);
    run_survey(50, 1);
    set_thresholds(16'd1, 15'd1);
    run_survey(50, 1);
    for (i = 0; i < 3; i++) begin
      set_thresholds(DIST_W'($urandom_range(0, 65535)), ANG_W'($urandom_range(0, 25736)));
      run_survey(60, 2);
    end
  endtask

  task automatic test_output_stall();
    set_thresholds(16'd1024, 15'd4000);
    hold_results = 1'b1;
    no_idle = 1'b1;
    run_survey(24, 0);
    no_idle = 1'b0;
    wait_drained();
    run_survey(24, 1);
  endtask

  task automatic test_random_traffic();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      set_thresholds(DIST_W'($urandom_range(8, 3000)), ANG_W'($urandom_range(100, 9000)));
      no_idle = (phase == 3);
      run_survey(200, phase % 3);
    end
    no_idle = 1'b0;
  endtask

  // result side: random ready/stall runs, plus a long hold on request
  initial begin : result_sink
    int ready_left, stall_left;
    ready_left = 0;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        stall_left = HOLD_CYCLES;
        hold_results = 1'b0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (ready_left > 0) begin
          ready_left--;
        end else begin
          ready_left = $urandom_range(1, 24);
          stall_left = idle_gap();
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result with none pending: visited %0b count %0d dropped %0b",
                 $time, out_already_visited, out_stored_count, out_dropped);
      end else begin
        want = expected_verdicts.pop_front();
        if (out_already_visited !== want.hit) begin
          mismatches++;
          $display("%0t: already_visited expected %0b actual %0b",
                   $time, want.hit, out_already_visited);
        end
        if (out_stored_count !== want.count) begin
          mismatches++;
          $display("%0t: stored_count expected %0d actual %0d",
                   $time, want.count, out_stored_count);
        end
        if (out_dropped !== want.drop) begin
          mismatches++;
          $display("%0t: dropped expected %0b actual %0b", $time, want.drop, out_dropped);
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_kind    <= KIND_RECORD;
    in_pos_x   <= '0;
    in_pos_y   <= '0;
    in_pos_z   <= '0;
    in_heading <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= CFG_DIST;
    cfg_data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_table_capacity();
    test_threshold_extremes();
    test_output_stall();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

>>> revisited_pose_matcher.f
hw/rtl/rpm_pkg.sv
hw/rtl/rpm_pose_mem.sv
hw/rtl/revisited_pose_matcher.sv
dv/testbench.sv
